### hw/rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg - shared types and constants of the serial line editor
// Item layouts of both channels, the front-to-back command word and the
// character codes that the editor recognises.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  // Widest buffer index over the supported line capacities
  localparam int IDX_W = 8;

  // Entries of the command queue between front and back (power of two)
  localparam int CMDQ_DEPTH = 4;

  localparam logic [7:0] CH_BEL      = 8'd7;
  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_SP       = 8'd32;
  localparam logic [7:0] CH_DEL      = 8'd127;
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;

  typedef enum logic [1:0] {
    RK_ECHO = 2'd0,
    RK_LINE = 2'd1,
    RK_ARG  = 2'd2,
    RK_READ = 2'd3
  } result_kind_t;

  typedef enum logic [2:0] {
    OP_STORE  = 3'd0,
    OP_RUBOUT = 3'd1,
    OP_EOL    = 3'd2,
    OP_BELL   = 3'd3,
    OP_READ   = 3'd4
  } cmd_op_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } in_item_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [7:0]   out_byte;
    logic [5:0]   line_length;
    logic [4:0]   arg_count;
    logic [5:0]   arg_start;
    logic [5:0]   arg_end;
    logic         arg_overflow;
    logic         last;
  } out_item_t;

  // idx: store address, read address or line length, by op
  typedef struct packed {
    cmd_op_t          op;
    logic [7:0]       ch;
    logic [IDX_W-1:0] idx;
    logic             rd_ok;
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/sle_ram.sv
// ----------------------------------------------------------------------------
// sle_ram - generic simple dual-port RAM
// One write port and one read port; read data registered and held while
// no read is requested.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/sle_front.sv
// ----------------------------------------------------------------------------
// sle_front - item intake and classification
// Accepts items, tracks the cursor and turns each item into one command
// for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_front #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sle_pkg::in_item_t in_item,
  input  logic             q_full,
  output logic             full,
  output logic             cmd_push,
  output sle_pkg::cmd_t    cmd
);
  import sle_pkg::*;

  localparam int AW = $clog2(LINE_CAPACITY);

  logic [AW-1:0] cursor_r, cursor_nxt;
  logic          accept;
  logic [8:0]    ri_w;
  logic [7:0]    ch;
  cmd_t          cmd_c;

  always_comb begin
    accept     = push && !q_full;
    ch         = in_item.rx_byte;
    ri_w       = {3'b000, in_item.read_index};
    cursor_nxt = cursor_r;
    cmd_c      = '0;
    cmd_c.ch   = ch;
    priority if (in_item.kind) begin
      cmd_c.op    = OP_READ;
      cmd_c.idx   = IDX_W'(in_item.read_index);
      cmd_c.rd_ok = ri_w < 9'(LINE_CAPACITY);
    end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI &&
                 cursor_r < AW'(LINE_CAPACITY - 2)) begin
      cmd_c.op   = OP_STORE;
      cmd_c.idx  = IDX_W'(cursor_r);
      cursor_nxt = cursor_r + AW'(1);
    end else if ((ch == CH_BS || ch == CH_DEL) && cursor_r != '0) begin
      cmd_c.op   = OP_RUBOUT;
      cursor_nxt = cursor_r - AW'(1);
    end else if (ch == CH_CR || ch == CH_LF) begin
      cmd_c.op   = OP_EOL;
      cmd_c.idx  = IDX_W'(cursor_r);
      cursor_nxt = '0;
    end else begin
      cmd_c.op = OP_BELL;
    end
    // hold the cursor unless the item is taken
    if (!accept) begin
      cursor_nxt = cursor_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
    end else begin
      cursor_r <= cursor_nxt;
    end
  end

  assign full     = q_full;
  assign cmd_push = accept;
  assign cmd      = cmd_c;

endmodule

`default_nettype wire

### hw/rtl/sle_cmdq.sv
// ----------------------------------------------------------------------------
// sle_cmdq - command queue between front and back
// Small register FIFO; head entry always visible.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  sle_pkg::cmd_t wr_cmd,
  input  logic          rd_en,
  output logic          full,
  output logic          empty,
  output sle_pkg::cmd_t head
);
  import sle_pkg::*;

  localparam int PW   = $clog2(CMDQ_DEPTH);
  localparam int CNTW = PW + 1;

  cmd_t            mem_r [CMDQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic            do_wr, do_rd;

  assign full  = cnt_r == CNTW'(CMDQ_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      priority if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CNTW'(1);
      end else begin
        cnt_r <= cnt_r;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sle_back.sv
// ----------------------------------------------------------------------------
// sle_back - command execution
// Runs commands in order: echoes, line buffer writes and reads, and the
// argument scan of a completed line. Drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_back #(
  parameter int LINE_CAPACITY = 64,
  parameter int MAX_ARGS      = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  sle_pkg::cmd_t      cmd_head,
  output logic               cmd_pop,
  input  logic               pop,
  output logic               out_valid,
  output sle_pkg::out_item_t out_item
);
  import sle_pkg::*;

  localparam int AW  = $clog2(LINE_CAPACITY);
  localparam int AIW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
  localparam int TW  = $clog2(MAX_ARGS + 2);
  localparam int RW  = 2 * AW;
  localparam logic [TW-1:0] MAX_T = TW'(MAX_ARGS);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_RUB1 = 9'b000000010,
    ST_RUB2 = 9'b000000100,
    ST_LF   = 9'b000001000,
    ST_SCAN = 9'b000010000,
    ST_FIN  = 9'b000100000,
    ST_AREQ = 9'b001000000,
    ST_AOUT = 9'b010000000,
    ST_RD   = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  logic            out_v_r, out_v_nxt;
  out_item_t       out_r, out_nxt;
  logic [AW-1:0]   len_r, len_nxt;
  logic [AW-1:0]   rd_idx_r, rd_idx_nxt;
  logic            p_v_r, p_v_nxt;
  logic [AW-1:0]   p_idx_r, p_idx_nxt;
  logic            pend_r, pend_nxt;
  logic [TW-1:0]   total_r, total_nxt;
  logic [AW-1:0]   start_r, start_nxt;
  logic [AIW-1:0]  ai_r, ai_nxt;
  logic            rd_ok_r, rd_ok_nxt;

  logic            line_we, line_re;
  logic [AW-1:0]   line_waddr, line_raddr;
  logic [7:0]      line_wdata, line_rdata;
  logic            arg_we, arg_re;
  logic [AIW-1:0]  arg_waddr, arg_raddr;
  logic [RW-1:0]   arg_wdata, arg_rdata;

  logic            slot_free, emit, issue;
  out_item_t       eitem;
  logic [TW-1:0]   rec, tm1, ai_p1;
  logic [TW+4:0]   rec_w;
  logic [AW+5:0]   len_w, ast_w, aen_w;

  sle_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY), .ADDR_W(AW)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  sle_ram #(.WIDTH(RW), .DEPTH(MAX_ARGS), .ADDR_W(AIW)) u_arg_ram (
    .clk   (clk),
    .we    (arg_we),
    .waddr (arg_waddr),
    .wdata (arg_wdata),
    .re    (arg_re),
    .raddr (arg_raddr),
    .rdata (arg_rdata)
  );

  assign slot_free = !out_v_r || pop;
  assign rec       = (total_r > MAX_T) ? MAX_T : total_r;
  assign tm1       = total_r - TW'(1);
  assign ai_p1     = TW'(ai_r) + TW'(1);
  assign rec_w     = {5'b00000, rec};
  assign len_w     = {6'b000000, len_r};
  assign ast_w     = {6'b000000, arg_rdata[RW-1:AW]};
  assign aen_w     = {6'b000000, arg_rdata[AW-1:0]};
  assign issue     = rd_idx_r != len_r;

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    rd_idx_nxt = rd_idx_r;
    p_v_nxt    = p_v_r;
    p_idx_nxt  = p_idx_r;
    pend_nxt   = pend_r;
    total_nxt  = total_r;
    start_nxt  = start_r;
    ai_nxt     = ai_r;
    rd_ok_nxt  = rd_ok_r;
    cmd_pop    = 1'b0;
    line_we    = 1'b0;
    line_waddr = cmd_head.idx[AW-1:0];
    line_wdata = cmd_head.ch;
    line_re    = 1'b0;
    line_raddr = cmd_head.idx[AW-1:0];
    arg_we     = 1'b0;
    arg_waddr  = tm1[AIW-1:0];
    arg_wdata  = {start_r, p_idx_r};
    arg_re     = 1'b0;
    arg_raddr  = ai_r;
    emit       = 1'b0;
    eitem      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          unique case (cmd_head.op)
            OP_STORE: begin
              if (slot_free) begin
                emit           = 1'b1;
                eitem.out_byte = cmd_head.ch;
                eitem.last     = 1'b1;
                line_we        = 1'b1;
                cmd_pop        = 1'b1;
              end
            end
            OP_BELL: begin
              if (slot_free) begin
                emit           = 1'b1;
                eitem.out_byte = CH_BEL;
                eitem.last     = 1'b1;
                cmd_pop        = 1'b1;
              end
            end
            OP_RUBOUT: begin
              if (slot_free) begin
                emit           = 1'b1;
                eitem.out_byte = CH_BS;
                cmd_pop        = 1'b1;
                state_nxt      = ST_RUB1;
              end
            end
            OP_EOL: begin
              if (slot_free) begin
                emit           = 1'b1;
                eitem.out_byte = CH_CR;
                len_nxt        = cmd_head.idx[AW-1:0];
                cmd_pop        = 1'b1;
                state_nxt      = ST_LF;
              end
            end
            OP_READ: begin
              line_re   = 1'b1;
              rd_ok_nxt = cmd_head.rd_ok;
              cmd_pop   = 1'b1;
              state_nxt = ST_RD;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_RUB1: begin
        if (slot_free) begin
          emit           = 1'b1;
          eitem.out_byte = CH_SP;
          state_nxt      = ST_RUB2;
        end
      end
      ST_RUB2: begin
        if (slot_free) begin
          emit           = 1'b1;
          eitem.out_byte = CH_BS;
          eitem.last     = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_LF: begin
        if (slot_free) begin
          emit           = 1'b1;
          eitem.out_byte = CH_LF;
          rd_idx_nxt     = '0;
          p_v_nxt        = 1'b0;
          pend_nxt       = 1'b1;
          total_nxt      = '0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read one byte a cycle, judge it the cycle after
        line_re    = issue;
        line_raddr = rd_idx_r;
        p_v_nxt    = issue;
        p_idx_nxt  = rd_idx_r;
        if (issue) begin
          rd_idx_nxt = rd_idx_r + AW'(1);
        end
        if (p_v_r) begin
          if (pend_r) begin
            pend_nxt = 1'b0;
            if (total_r < MAX_T) begin
              start_nxt = p_idx_r;
            end
            if (total_r <= MAX_T) begin
              total_nxt = total_r + TW'(1);
            end
          end else if (line_rdata == CH_SP) begin
            arg_we   = total_r <= MAX_T;
            pend_nxt = 1'b1;
          end
        end
        if (!issue && !p_v_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // close an argument left open at the line end
        arg_wdata = {start_r, len_r};
        arg_we    = !pend_r && total_r != '0 && total_r <= MAX_T;
        if (slot_free) begin
          emit               = 1'b1;
          eitem.result_kind  = RK_LINE;
          eitem.line_length  = len_w[5:0];
          eitem.arg_count    = rec_w[4:0];
          eitem.arg_overflow = total_r > MAX_T;
          eitem.last         = rec == '0;
          ai_nxt             = '0;
          state_nxt          = (rec == '0) ? ST_IDLE : ST_AREQ;
        end
      end
      ST_AREQ: begin
        arg_re    = 1'b1;
        state_nxt = ST_AOUT;
      end
      ST_AOUT: begin
        if (slot_free) begin
          emit              = 1'b1;
          eitem.result_kind = RK_ARG;
          eitem.arg_start   = ast_w[5:0];
          eitem.arg_end     = aen_w[5:0];
          eitem.last        = ai_p1 == rec;
          ai_nxt            = ai_r + AIW'(1);
          state_nxt         = (ai_p1 == rec) ? ST_IDLE : ST_AREQ;
        end
      end
      ST_RD: begin
        if (slot_free) begin
          emit              = 1'b1;
          eitem.result_kind = RK_READ;
          eitem.out_byte    = rd_ok_r ? line_rdata : 8'd0;
          eitem.last        = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    if (emit) begin
      out_v_nxt = 1'b1;
      out_nxt   = eitem;
    end else if (pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r    <= out_nxt;
    len_r    <= len_nxt;
    rd_idx_r <= rd_idx_nxt;
    p_v_r    <= p_v_nxt;
    p_idx_r  <= p_idx_nxt;
    pend_r   <= pend_nxt;
    total_r  <= total_nxt;
    start_r  <= start_nxt;
    ai_r     <= ai_nxt;
    rd_ok_r  <= rd_ok_nxt;
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

### hw/rtl/serial_line_editor_tokenizer.sv
// ----------------------------------------------------------------------------
// serial_line_editor_tokenizer - serial console line editor
// Echoes and edits received console bytes into a line buffer, splits a
// completed line into space-separated arguments and reads stored bytes back.
// ----------------------------------------------------------------------------
//
//  channel   ports                 moves                     taken when
//  --------  --------------------  ------------------------  ----------------
//  input     push, full, in_item   console byte or read      push && !full
//  result    empty, pop, out_item  echo, line, arg, read     pop && !empty
//
// Flow: the front takes one item a cycle while its four-entry command
// queue has room. The back runs one command at a time: a stored byte is
// echoed and a bell answered with BEL; a rubout echoes BS, SP, BS; a read
// is a line RAM read then the result; a line end echoes CR and LF, then
// scans the line RAM, pipelined, one byte a cycle, then gives the line record
// and, per recorded argument, an arg RAM read then the result.
// Reset: synchronous, active low; clears the cursor, queue and result
// register. The line buffer is not cleared.
// Stalls: a held result stops the back only; the front keeps filling the
// queue until it is full.
//
`default_nettype none

module serial_line_editor_tokenizer #(
  parameter int LINE_CAPACITY = 64,
  parameter int MAX_ARGS      = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  sle_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output sle_pkg::out_item_t out_item
);
  import sle_pkg::*;

  logic cmd_push, cmd_full, cmd_empty, cmd_pop, out_valid;
  cmd_t cmd_in, cmd_head;

  // Classify items and keep the cursor
  sle_front #(.LINE_CAPACITY(LINE_CAPACITY)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .q_full   (cmd_full),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // Decouple intake from execution
  sle_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_cmd (cmd_in),
    .rd_en  (cmd_pop),
    .full   (cmd_full),
    .empty  (cmd_empty),
    .head   (cmd_head)
  );

  // Execute commands in order and present results
  sle_back #(.LINE_CAPACITY(LINE_CAPACITY), .MAX_ARGS(MAX_ARGS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign empty = !out_valid;

  // The front never pushes a command into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_full)
    else $error("command pushed into full queue");

  // The back only takes a command that is there
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from empty queue");

  // No result survives a reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result pending after reset");

endmodule

`default_nettype wire

### verif/serial_line_editor_tokenizer_test.sv
// ----------------------------------------------------------------------------
// serial_line_editor_tokenizer_test - self-checking bench of the line editor
// Feeds console bytes and buffer reads through the input queue, keeps a
// line model of its own to work out every echo, line and argument record,
// and checks each popped result against the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module serial_line_editor_tokenizer_test;
  import sle_pkg::*;

  localparam int LINE_CAP     = 64;
  localparam int ARG_LIMIT    = 16;
  localparam int MAX_PER_ITEM = 19;
  localparam int RANDOM_ITEMS = 290;
  localparam int HOLD_CYCLES  = 300;
  // Longest line end: scan of a full line plus the argument records
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 400000;

  // One row of the directed table; want_* is only meaningful when typed
  typedef struct packed {
    in_item_t     item;
    logic         typed;
    result_kind_t want_kind;
    logic [7:0]   want_byte;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  // Line model: buffer contents, cursor and the written prefix
  logic [7:0] line_model [0:LINE_CAP-1];
  int         model_cursor;
  int         written_top;

  // Results of the item just accepted, and those still to be popped
  out_item_t  step_results [0:MAX_PER_ITEM-1];
  int         step_count;
  out_item_t  awaited_results [$];

  stim_row_t  directed_rows [$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_asks;
  int hold_seen;
  int hold_left;
  int cycle_count;
  int errors;
  int items_sent;
  int random_items;
  int results_checked;
  int lines_done;
  int overflow_lines;
  int full_refusals;

  serial_line_editor_tokenizer #(
    .LINE_CAPACITY(LINE_CAP),
    .MAX_ARGS     (ARG_LIMIT)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: give up well past the slowest correct run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Line model
  // --------------------------------------------------------------------------

  // Append one result with every field not named cleared
  function automatic void add_step(result_kind_t kind, logic [7:0] value);
    out_item_t r;
    r = '0;
    r.result_kind = kind;
    r.out_byte    = value;
    step_results[step_count] = r;
    step_count++;
  endfunction

  // Work out the results of one accepted item and advance the line model
  function automatic void edit_line_model(in_item_t it);
    int   starts [0:ARG_LIMIT-1];
    int   ends   [0:ARG_LIMIT-1];
    int   total;
    int   kept;
    bit   pending;
    logic [7:0] ch;
    step_count = 0;
    total      = 0;
    pending    = 1'b1;
    ch         = it.rx_byte;
    if (it.kind) begin
      add_step(RK_READ, line_model[it.read_index]);
    end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI && model_cursor < LINE_CAP - 2) begin
      add_step(RK_ECHO, ch);
      line_model[model_cursor] = ch;
      model_cursor++;
      if (model_cursor > written_top) written_top = model_cursor;
    end else if ((ch == CH_BS || ch == CH_DEL) && model_cursor > 0) begin
      add_step(RK_ECHO, CH_BS);
      add_step(RK_ECHO, CH_SP);
      add_step(RK_ECHO, CH_BS);
      model_cursor--;
    end else if (ch == CH_CR || ch == CH_LF) begin
      add_step(RK_ECHO, CH_CR);
      add_step(RK_ECHO, CH_LF);
      // Split: the byte at a start index is taken as is, even a space
      for (int i = 0; i < model_cursor; i++) begin
        if (pending) begin
          pending = 1'b0;
          if (total < ARG_LIMIT) begin
            starts[total] = i;
            ends[total]   = model_cursor;
          end
          total++;
        end else if (line_model[i] == CH_SP) begin
          if (total <= ARG_LIMIT) ends[total-1] = i;
          pending = 1'b1;
        end
      end
      kept = (total < ARG_LIMIT) ? total : ARG_LIMIT;
      add_step(RK_LINE, 8'd0);
      step_results[step_count-1].line_length  = 6'(model_cursor);
      step_results[step_count-1].arg_count    = 5'(kept);
      step_results[step_count-1].arg_overflow = (total > ARG_LIMIT);
      for (int a = 0; a < kept; a++) begin
        add_step(RK_ARG, 8'd0);
        step_results[step_count-1].arg_start = 6'(starts[a]);
        step_results[step_count-1].arg_end   = 6'(ends[a]);
      end
      lines_done++;
      if (total > ARG_LIMIT) overflow_lines++;
      model_cursor = 0;
    end else begin
      if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) full_refusals++;
      add_step(RK_ECHO, CH_BEL);
    end
    step_results[step_count-1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Compare a popped result with the oldest expectation, field by field
  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (awaited_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got %h", $time, got);
    end else begin
      want = awaited_results.pop_front();
      check_field("result_kind",  8'(want.result_kind),  8'(got.result_kind));
      check_field("out_byte",     want.out_byte,         got.out_byte);
      check_field("line_length",  8'(want.line_length),  8'(got.line_length));
      check_field("arg_count",    8'(want.arg_count),    8'(got.arg_count));
      check_field("arg_start",    8'(want.arg_start),    8'(got.arg_start));
      check_field("arg_end",      8'(want.arg_end),      8'(got.arg_end));
      check_field("arg_overflow", 8'(want.arg_overflow), 8'(got.arg_overflow));
      check_field("last",         8'(want.last),         8'(got.last));
    end
    results_checked++;
  endfunction

  // Receiver: take a result when pop met a non-empty queue, then pick the
  // next pop; a hold request from the stimulus freezes pop for a long stretch
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) check_result(out_item);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one item until taken, then record what it must cause.
  // Idle cycles go in front; push stays high between back-to-back items.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    edit_line_model(it);
    if (typed) begin
      awaited_results.push_back(want);
    end else begin
      for (int i = 0; i < step_count; i++) awaited_results.push_back(step_results[i]);
    end
    items_sent++;
  endtask

  // Console byte with a random, unused read index
  task automatic send_console(input logic [7:0] ch);
    in_item_t it;
    it.kind       = 1'b0;
    it.rx_byte    = ch;
    it.read_index = 6'($urandom_range(0, 63));
    send_item(it, 1'b0, '0);
    random_items++;
  endtask

  // Read back a buffer entry, only from the prefix already written
  task automatic maybe_read(input int pct);
    in_item_t it;
    if (written_top > 0 && $urandom_range(0, 99) < pct) begin
      it.kind       = 1'b1;
      it.rx_byte    = 8'($urandom_range(0, 255));
      it.read_index = 6'($urandom_range(0, written_top - 1));
      send_item(it, 1'b0, '0);
      random_items++;
    end
  endtask

  function automatic logic [7:0] pick_eol();
    return $urandom_range(0, 1) ? CH_CR : CH_LF;
  endfunction

  // One random burst: mostly well-formed lines with random words, some
  // noise, lines with too many arguments and lines that overrun the buffer
  task automatic send_random_line();
    int mode;
    int count;
    int wlen;
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      // Noise: any byte value at all
      repeat ($urandom_range(1, 6)) send_console(8'($urandom_range(0, 255)));
    end else if (mode < 16) begin
      // Single-letter arguments, around and beyond the argument limit
      count = $urandom_range(ARG_LIMIT - 2, 31);
      repeat (count) begin
        send_console(8'($urandom_range(33, 126)));
        send_console(CH_SP);
      end
      send_console(pick_eol());
    end else if (mode < 22) begin
      // Overrun the buffer, rub one out and refill it
      count = $urandom_range(LINE_CAP - 4, LINE_CAP + 4);
      repeat (count) send_console(8'($urandom_range(32, 126)));
      send_console($urandom_range(0, 1) ? CH_BS : CH_DEL);
      send_console(8'($urandom_range(32, 126)));
      maybe_read(50);
      send_console(pick_eol());
    end else begin
      if ($urandom_range(0, 3) == 0) send_console(CH_SP);
      count = $urandom_range(1, 6);
      for (int w = 0; w < count; w++) begin
        wlen = $urandom_range(1, 8);
        repeat (wlen) begin
          send_console(8'($urandom_range(33, 126)));
          if ($urandom_range(0, 99) < 8) send_console($urandom_range(0, 1) ? CH_BS : CH_DEL);
          maybe_read(12);
        end
        repeat ($urandom_range(1, 2)) send_console(CH_SP);
      end
      // Now and then leave the line open so the next burst extends it
      if ($urandom_range(0, 99) < 90) send_console(pick_eol());
    end
  endtask

  function automatic void add_row(logic kind, logic [7:0] ch, logic [5:0] idx, logic typed,
                                  result_kind_t want_kind, logic [7:0] want_byte);
    stim_row_t row;
    row.item.kind       = kind;
    row.item.rx_byte    = ch;
    row.item.read_index = idx;
    row.typed           = typed;
    row.want_kind       = want_kind;
    row.want_byte       = want_byte;
    directed_rows.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    out_item_t want;
    rst_n   <= 1'b0;
    push    <= 1'b0;
    in_item <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks     = 0;
    hold_seen     = 0;
    hold_left     = 0;
    model_cursor  = 0;
    written_top   = 0;

    // Hold reset, then release it before sending anything
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: rubouts on an empty line, a line end on an empty line,
    // bytes outside the printable range, a line starting with a space, a line ending
    // with one, rubouts, reads of the open line and of bytes left by earlier lines
    add_row(1'b0, CH_BS,       6'd0,  1'b1, RK_ECHO, CH_BEL);
    add_row(1'b0, CH_DEL,      6'd0,  1'b1, RK_ECHO, CH_BEL);
    add_row(1'b0, CH_CR,       6'd0,  1'b0, RK_ECHO, 8'd0);
    add_row(1'b0, 8'd0,        6'h3F, 1'b1, RK_ECHO, CH_BEL);
    add_row(1'b0, 8'hFF,       6'h2A, 1'b1, RK_ECHO, CH_BEL);
    add_row(1'b0, 8'd31,       6'h15, 1'b1, RK_ECHO, CH_BEL);
    add_row(1'b0, CH_SP,       6'd0,  1'b1, RK_ECHO, CH_SP);
    add_row(1'b0, 8'd120,      6'd0,  1'b1, RK_ECHO, 8'd120);
    add_row(1'b0, CH_SP,       6'd0,  1'b1, RK_ECHO, CH_SP);
    add_row(1'b0, CH_SP,       6'd0,  1'b1, RK_ECHO, CH_SP);
    add_row(1'b0, CH_PRINT_HI, 6'd0,  1'b1, RK_ECHO, CH_PRINT_HI);
    add_row(1'b1, 8'd0,        6'd0,  1'b1, RK_READ, CH_SP);
    add_row(1'b1, 8'hFF,       6'd4,  1'b1, RK_READ, CH_PRINT_HI);
    add_row(1'b0, CH_DEL,      6'd0,  1'b0, RK_ECHO, 8'd0);
    add_row(1'b0, CH_BS,       6'd0,  1'b0, RK_ECHO, 8'd0);
    add_row(1'b0, 8'd113,      6'd0,  1'b1, RK_ECHO, 8'd113);
    add_row(1'b0, CH_LF,       6'd0,  1'b0, RK_ECHO, 8'd0);
    add_row(1'b1, 8'd0,        6'd1,  1'b1, RK_READ, 8'd120);
    add_row(1'b1, 8'd0,        6'd3,  1'b1, RK_READ, 8'd113);
    add_row(1'b0, 8'd97,       6'd0,  1'b1, RK_ECHO, 8'd97);
    add_row(1'b0, 8'd98,       6'd0,  1'b1, RK_ECHO, 8'd98);
    add_row(1'b0, CH_SP,       6'd0,  1'b1, RK_ECHO, CH_SP);
    add_row(1'b0, CH_CR,       6'd0,  1'b0, RK_ECHO, 8'd0);

    // Phase 1: sender mostly busy, receiver mostly idle
    send_idle_pct = 11;
    recv_idle_pct = 65;
    foreach (directed_rows[i]) begin
      want             = '0;
      want.result_kind = directed_rows[i].want_kind;
      want.out_byte    = directed_rows[i].want_byte;
      want.last        = 1'b1;
      send_item(directed_rows[i].item, directed_rows[i].typed, want);
    end

    // Stop popping for a long while so the queues fill and full rises
    hold_asks++;
    while (random_items < RANDOM_ITEMS / 3) send_random_line();

    // Phase 2: roles swapped
    send_idle_pct = 65;
    recv_idle_pct = 11;
    while (random_items < 2 * RANDOM_ITEMS / 3) send_random_line();

    // Phase 3: both sides flat out, after one more long hold
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks++;
    while (random_items < RANDOM_ITEMS) send_random_line();
    push <= 1'b0;

    // Drain, then allow for any stray result
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d directed, %0d random), checked %0d results.",
             items_sent, directed_rows.size(), random_items, results_checked);
    $display("Completed %0d lines, %0d over the argument limit, %0d bytes refused on a full line.",
             lines_done, overflow_lines, full_refusals);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sle_pkg.sv
hw/rtl/sle_ram.sv
hw/rtl/sle_front.sv
hw/rtl/sle_cmdq.sv
hw/rtl/sle_back.sv
hw/rtl/serial_line_editor_tokenizer.sv
verif/serial_line_editor_tokenizer_test.sv
